>>> src/nst_pkg.sv
// Shared types, sizes, command and result codes for the named semaphore table.
// Used by every module of the block except nst_ram; depends on nothing.
package nst_pkg;

    localparam int SEM_SLOTS     = 32;
    localparam int PROCESS_SLOTS = 64;
    localparam int NAME_BYTES    = 8;

    localparam int SLOT_W  = (SEM_SLOTS > 1) ? $clog2(SEM_SLOTS) : 1;
    localparam int PIDX_W  = $clog2(PROCESS_SLOTS);
    localparam int FILL_W  = PIDX_W + 1;
    localparam int PID_W   = 6;
    localparam int KEY_W   = 64;
    localparam int INIT_W  = 31;
    localparam int VAL_W   = 32;
    localparam int USERS_W = 8;
    localparam int QDEPTH  = 2;

    localparam logic [KEY_W-1:0] KEY_MASK = {KEY_W{1'b1}} >> (KEY_W - 8 * NAME_BYTES);
    localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    localparam logic [2:0] CMD_OPEN    = 3'd0;
    localparam logic [2:0] CMD_WAIT    = 3'd1;
    localparam logic [2:0] CMD_POST    = 3'd2;
    localparam logic [2:0] CMD_CLOSE   = 3'd3;
    localparam logic [2:0] CMD_CLEANUP = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    localparam logic [1:0] ACT_NONE  = 2'd0;
    localparam logic [1:0] ACT_BLOCK = 2'd1;
    localparam logic [1:0] ACT_WAKE  = 2'd2;

    typedef enum logic [2:0] {
        OP_OPEN,
        OP_WAIT,
        OP_POST,
        OP_CLOSE,
        OP_CLEANUP,
        OP_BAD
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [KEY_W-1:0]   key;
        logic [INIT_W-1:0]  init;
        logic [PID_W-1:0]   cpid;
        logic               cvalid;
        logic [PID_W-1:0]   tpid;
    } item_t;

    function automatic logic signed [VAL_W-1:0] sat_inc(input logic signed [VAL_W-1:0] v);
        return (v == VAL_MAX) ? v : v + VAL_W'(1);
    endfunction

    function automatic logic signed [VAL_W-1:0] sat_dec(input logic signed [VAL_W-1:0] v);
        return (v == VAL_MIN) ? v : v - VAL_W'(1);
    endfunction

endpackage

>>> src/nst_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module nst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> src/nst_front.sv
// Input stage: takes command transfers, decodes the command and masks the name.
// Depends on nst_pkg.
module nst_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [2:0]          in_cmd,
    input  logic [111:0]        in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output nst_pkg::item_t      out_item
);

    logic           full_reg;
    nst_pkg::item_t item_reg;
    nst_pkg::op_t   op_dec;

    always_comb
    begin
        unique case (in_cmd)
            nst_pkg::CMD_OPEN:    op_dec = nst_pkg::OP_OPEN;
            nst_pkg::CMD_WAIT:    op_dec = nst_pkg::OP_WAIT;
            nst_pkg::CMD_POST:    op_dec = nst_pkg::OP_POST;
            nst_pkg::CMD_CLOSE:   op_dec = nst_pkg::OP_CLOSE;
            nst_pkg::CMD_CLEANUP: op_dec = nst_pkg::OP_CLEANUP;
            default:              op_dec = nst_pkg::OP_BAD;
        endcase
    end

    assign in_ready  = !full_reg || out_ready;
    assign out_valid = full_reg;
    assign out_item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            full_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            full_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg.op     <= op_dec;
            item_reg.key    <= in_data[63:0] & nst_pkg::KEY_MASK;
            item_reg.init   <= in_data[94:64];
            item_reg.cpid   <= in_data[100:95];
            item_reg.cvalid <= in_data[101];
            item_reg.tpid   <= in_data[107:102];
        end
    end

endmodule

>>> src/nst_fifo.sv
// Short command queue between the decode stage and the execution engine.
// Depends on nst_pkg.
module nst_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  nst_pkg::item_t push_item,
    output logic           pop_valid,
    input  logic           pop_ready,
    output nst_pkg::item_t pop_item
);

    localparam int PW = (nst_pkg::QDEPTH > 1) ? $clog2(nst_pkg::QDEPTH) : 1;

    nst_pkg::item_t   store [nst_pkg::QDEPTH];
    logic [PW-1:0]    wr_reg;
    logic [PW-1:0]    rd_reg;
    logic [PW:0]      cnt_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = cnt_reg != (PW+1)'(nst_pkg::QDEPTH);
    assign pop_valid  = cnt_reg != '0;
    assign pop_item   = store[rd_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_reg <= (wr_reg == PW'(nst_pkg::QDEPTH - 1)) ? '0 : wr_reg + PW'(1);
            end
            if (do_pop)
            begin
                rd_reg <= (rd_reg == PW'(nst_pkg::QDEPTH - 1)) ? '0 : rd_reg + PW'(1);
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + (PW+1)'(1);
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - (PW+1)'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store[wr_reg] <= push_item;
        end
    end

endmodule

>>> src/nst_back.sv
// Execution engine: slot table, wait queues, held maps and result register.
// Depends on nst_pkg and nst_ram.
module nst_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    output logic           cmd_ready,
    input  nst_pkg::item_t cmd_item,
    output logic           res_valid,
    input  logic           res_ready,
    output logic [15:0]    res_data,
    output logic           res_last
);

    localparam int SW = nst_pkg::SLOT_W;
    localparam int PW = nst_pkg::PIDX_W;
    localparam int FW = nst_pkg::FILL_W;
    localparam int QW = SW + PW;

    typedef enum logic [4:0] {
        B_IDLE, B_MATCH, B_DECIDE, B_HRD, B_HWR, B_OKEMIT, B_PCHK, B_POP_RD, B_POP_WT,
        B_WDONE, B_EMIT, C_HMRD, C_HMWT, C_SLOT, C_SCAN_RD, C_SCAN_WT, C_COPY_RD,
        C_COPY_WT, C_HELD, C_NEXT, C_END
    } state_t;

    state_t                         state_reg;
    state_t                         h_ret_reg;
    state_t                         e_ret_reg;
    nst_pkg::item_t                 it_reg;

    logic [nst_pkg::KEY_W-1:0]      name_reg  [nst_pkg::SEM_SLOTS];
    logic signed [nst_pkg::VAL_W-1:0] value_reg [nst_pkg::SEM_SLOTS];
    logic [nst_pkg::USERS_W-1:0]    users_reg [nst_pkg::SEM_SLOTS];
    logic [PW-1:0]                  head_reg  [nst_pkg::SEM_SLOTS];
    logic [PW-1:0]                  tail_reg  [nst_pkg::SEM_SLOTS];
    logic [FW-1:0]                  fill_reg  [nst_pkg::SEM_SLOTS];
    logic [nst_pkg::PROCESS_SLOTS-1:0] hvalid_reg;

    logic [nst_pkg::SEM_SLOTS-1:0]  match_reg;
    logic [nst_pkg::SEM_SLOTS-1:0]  free_reg;
    logic [nst_pkg::SEM_SLOTS-1:0]  hm_reg;
    logic [SW-1:0]                  s_reg;
    logic [nst_pkg::PID_W-1:0]      h_pid_reg;
    logic [SW-1:0]                  h_bit_reg;
    logic                           h_set_reg;
    logic [nst_pkg::PID_W-1:0]      w_reg;
    logic                           pend_valid_reg;
    logic [nst_pkg::PID_W-1:0]      pend_pid_reg;
    logic [FW-1:0]                  i_reg;
    logic [FW-1:0]                  n_reg;
    logic                           hit_reg;
    logic [PW-1:0]                  rd_idx_reg;
    logic [1:0]                     e_status_reg;
    logic [1:0]                     e_action_reg;
    logic [nst_pkg::PID_W-1:0]      e_pid_reg;
    logic                           e_last_reg;
    logic                           out_valid_reg;
    logic [1:0]                     out_status_reg;
    logic [1:0]                     out_action_reg;
    logic [nst_pkg::PID_W-1:0]      out_pid_reg;
    logic                           out_last_reg;

    logic                           m_hit;
    logic [SW-1:0]                  m_idx;
    logic                           f_hit;
    logic [SW-1:0]                  f_idx;
    logic signed [nst_pkg::VAL_W-1:0] dec_val;
    logic signed [nst_pkg::VAL_W-1:0] inc_val;
    logic signed [nst_pkg::VAL_W-1:0] c_inc;
    logic                           val_we;
    logic [SW-1:0]                  val_addr;
    logic signed [nst_pkg::VAL_W-1:0] val_data;
    logic                           name_we;

    logic                           q_we;
    logic [QW-1:0]                  q_waddr;
    logic [nst_pkg::PID_W-1:0]      q_wdata;
    logic [QW-1:0]                  q_raddr;
    logic [nst_pkg::PID_W-1:0]      q_rdata;
    logic                           sc_we;
    logic [PW-1:0]                  sc_waddr;
    logic [PW-1:0]                  sc_raddr;
    logic [nst_pkg::PID_W-1:0]      sc_rdata;
    logic                           h_we;
    logic [PW-1:0]                  h_waddr;
    logic [nst_pkg::SEM_SLOTS-1:0]  h_wdata;
    logic [PW-1:0]                  h_raddr;
    logic [nst_pkg::SEM_SLOTS-1:0]  h_rdata;
    logic [nst_pkg::SEM_SLOTS-1:0]  h_base;
    logic                           out_free;

    nst_ram #(.WIDTH(nst_pkg::PID_W), .DEPTH(nst_pkg::SEM_SLOTS * nst_pkg::PROCESS_SLOTS))
    u_queue (
        .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
        .raddr(q_raddr), .rdata(q_rdata)
    );

    nst_ram #(.WIDTH(nst_pkg::PID_W), .DEPTH(nst_pkg::PROCESS_SLOTS))
    u_scratch (
        .clk(clk), .we(sc_we), .waddr(sc_waddr), .wdata(q_rdata),
        .raddr(sc_raddr), .rdata(sc_rdata)
    );

    nst_ram #(.WIDTH(nst_pkg::SEM_SLOTS), .DEPTH(nst_pkg::PROCESS_SLOTS))
    u_held (
        .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
        .raddr(h_raddr), .rdata(h_rdata)
    );

    assign cmd_ready = state_reg == B_IDLE;
    assign res_valid = out_valid_reg;
    assign res_data  = {4'b0, out_pid_reg, out_action_reg, out_status_reg};
    assign res_last  = out_last_reg;
    assign out_free  = !out_valid_reg || res_ready;

    always_comb
    begin
        m_hit = 1'b0;
        m_idx = '0;
        f_hit = 1'b0;
        f_idx = '0;
        for (int i = nst_pkg::SEM_SLOTS - 1; i >= 0; i--)
        begin
            if (match_reg[i])
            begin
                m_hit = 1'b1;
                m_idx = SW'(i);
            end
            if (free_reg[i])
            begin
                f_hit = 1'b1;
                f_idx = SW'(i);
            end
        end
        dec_val = nst_pkg::sat_dec(value_reg[m_idx]);
        inc_val = nst_pkg::sat_inc(value_reg[m_idx]);
        c_inc   = nst_pkg::sat_inc(value_reg[s_reg]);
        h_base  = hvalid_reg[PW'(h_pid_reg)] ? h_rdata : '0;

        val_we   = 1'b0;
        val_addr = m_idx;
        val_data = dec_val;
        name_we  = 1'b0;
        q_we     = 1'b0;
        q_waddr  = {m_idx, tail_reg[m_idx]};
        q_wdata  = it_reg.cpid;
        q_raddr  = {s_reg, head_reg[s_reg]};
        sc_we    = 1'b0;
        sc_waddr = PW'(n_reg);
        sc_raddr = PW'(i_reg);
        h_we     = 1'b0;
        h_waddr  = PW'(h_pid_reg);
        h_wdata  = h_set_reg ? (h_base | (nst_pkg::SEM_SLOTS'(1) << h_bit_reg))
                             : (h_base & ~(nst_pkg::SEM_SLOTS'(1) << h_bit_reg));
        h_raddr  = PW'(h_pid_reg);

        unique case (state_reg)
            B_DECIDE:
            begin
                if (it_reg.op == nst_pkg::OP_OPEN && !m_hit && f_hit)
                begin
                    name_we  = 1'b1;
                    val_we   = 1'b1;
                    val_addr = f_idx;
                    val_data = {1'b0, it_reg.init};
                end
                else if (it_reg.op == nst_pkg::OP_WAIT && m_hit)
                begin
                    val_we = 1'b1;
                    if (dec_val < 0 && it_reg.cvalid
                        && fill_reg[m_idx] < FW'(nst_pkg::PROCESS_SLOTS))
                    begin
                        q_we = 1'b1;
                    end
                end
                else if (it_reg.op == nst_pkg::OP_POST && m_hit)
                begin
                    val_we   = 1'b1;
                    val_data = inc_val;
                end
            end
            C_HMRD:
            begin
                h_raddr = PW'(it_reg.tpid);
            end
            B_HWR:
            begin
                h_we = 1'b1;
            end
            C_END:
            begin
                h_we    = 1'b1;
                h_waddr = PW'(it_reg.tpid);
                h_wdata = '0;
            end
            C_SCAN_RD:
            begin
                q_raddr = {s_reg, rd_idx_reg};
            end
            C_SCAN_WT:
            begin
                sc_we = q_rdata != it_reg.tpid;
            end
            C_COPY_RD:
            begin
                if (i_reg >= n_reg)
                begin
                    val_we   = 1'b1;
                    val_addr = s_reg;
                    val_data = c_inc;
                end
            end
            C_COPY_WT:
            begin
                q_we    = 1'b1;
                q_waddr = {s_reg, PW'(i_reg)};
                q_wdata = sc_rdata;
            end
            C_HELD:
            begin
                if (hm_reg[s_reg])
                begin
                    val_we   = 1'b1;
                    val_addr = s_reg;
                    val_data = c_inc;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (val_we)
        begin
            value_reg[val_addr] <= val_data;
        end
        if (name_we)
        begin
            name_reg[f_idx] <= it_reg.key;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= B_IDLE;
            h_ret_reg      <= B_IDLE;
            e_ret_reg      <= B_IDLE;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            hvalid_reg     <= '0;
            for (int i = 0; i < nst_pkg::SEM_SLOTS; i++)
            begin
                users_reg[i] <= '0;
                head_reg[i]  <= '0;
                tail_reg[i]  <= '0;
                fill_reg[i]  <= '0;
            end
        end
        else
        begin
            if (res_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (h_we)
            begin
                hvalid_reg[h_waddr] <= 1'b1;
            end
            if (q_we && state_reg == B_DECIDE)
            begin
                tail_reg[m_idx] <= tail_reg[m_idx] + PW'(1);
                fill_reg[m_idx] <= fill_reg[m_idx] + FW'(1);
            end

            unique case (state_reg)
                B_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        it_reg <= cmd_item;
                        if (cmd_item.op == nst_pkg::OP_BAD)
                        begin
                            e_status_reg <= nst_pkg::ST_NOTFOUND;
                            e_action_reg <= nst_pkg::ACT_NONE;
                            e_pid_reg    <= '0;
                            e_last_reg   <= 1'b1;
                            e_ret_reg    <= B_IDLE;
                            state_reg    <= B_EMIT;
                        end
                        else if (cmd_item.op == nst_pkg::OP_CLEANUP)
                        begin
                            state_reg <= C_HMRD;
                        end
                        else
                        begin
                            state_reg <= B_MATCH;
                        end
                    end
                end
                B_MATCH:
                begin
                    for (int i = 0; i < nst_pkg::SEM_SLOTS; i++)
                    begin
                        match_reg[i] <= users_reg[i] != '0 && name_reg[i] == it_reg.key;
                        free_reg[i]  <= users_reg[i] == '0;
                    end
                    state_reg <= B_DECIDE;
                end
                B_DECIDE:
                begin
                    s_reg        <= m_idx;
                    e_status_reg <= nst_pkg::ST_OK;
                    e_action_reg <= nst_pkg::ACT_NONE;
                    e_pid_reg    <= '0;
                    e_last_reg   <= 1'b1;
                    e_ret_reg    <= B_IDLE;
                    state_reg    <= B_EMIT;
                    h_pid_reg    <= it_reg.cpid;
                    h_bit_reg    <= m_idx;
                    h_set_reg    <= 1'b0;
                    if (it_reg.op == nst_pkg::OP_OPEN)
                    begin
                        if (m_hit)
                        begin
                            if (users_reg[m_idx] != '1)
                            begin
                                users_reg[m_idx] <= users_reg[m_idx] + 8'd1;
                            end
                        end
                        else if (f_hit)
                        begin
                            users_reg[f_idx] <= 8'd1;
                            head_reg[f_idx]  <= '0;
                            tail_reg[f_idx]  <= '0;
                            fill_reg[f_idx]  <= '0;
                        end
                        else
                        begin
                            e_status_reg <= nst_pkg::ST_FULL;
                        end
                    end
                    else if (!m_hit)
                    begin
                        e_status_reg <= nst_pkg::ST_NOTFOUND;
                    end
                    else if (it_reg.op == nst_pkg::OP_WAIT)
                    begin
                        if (dec_val < 0)
                        begin
                            if (!it_reg.cvalid)
                            begin
                                e_status_reg <= nst_pkg::ST_NOTFOUND;
                            end
                            else
                            begin
                                e_action_reg <= nst_pkg::ACT_BLOCK;
                                e_pid_reg    <= it_reg.cpid;
                            end
                        end
                        else if (it_reg.cvalid)
                        begin
                            h_set_reg <= 1'b1;
                            h_ret_reg <= B_OKEMIT;
                            state_reg <= B_HRD;
                        end
                    end
                    else if (it_reg.op == nst_pkg::OP_POST)
                    begin
                        h_ret_reg <= B_PCHK;
                        state_reg <= it_reg.cvalid ? B_HRD : B_PCHK;
                    end
                    else
                    begin
                        users_reg[m_idx] <= users_reg[m_idx] - 8'd1;
                        if (users_reg[m_idx] == 8'd1)
                        begin
                            head_reg[m_idx] <= '0;
                            tail_reg[m_idx] <= '0;
                            fill_reg[m_idx] <= '0;
                        end
                        if (it_reg.cvalid)
                        begin
                            h_ret_reg <= B_OKEMIT;
                            state_reg <= B_HRD;
                        end
                    end
                end
                B_HRD:
                begin
                    state_reg <= B_HWR;
                end
                B_HWR:
                begin
                    state_reg <= h_ret_reg;
                end
                B_OKEMIT:
                begin
                    e_status_reg <= nst_pkg::ST_OK;
                    e_action_reg <= nst_pkg::ACT_NONE;
                    e_pid_reg    <= '0;
                    e_last_reg   <= 1'b1;
                    e_ret_reg    <= B_IDLE;
                    state_reg    <= B_EMIT;
                end
                B_PCHK:
                begin
                    state_reg <= (value_reg[s_reg] <= 0 && fill_reg[s_reg] != '0)
                                 ? B_POP_RD : B_OKEMIT;
                end
                B_POP_RD:
                begin
                    head_reg[s_reg] <= head_reg[s_reg] + PW'(1);
                    fill_reg[s_reg] <= fill_reg[s_reg] - FW'(1);
                    state_reg       <= B_POP_WT;
                end
                B_POP_WT:
                begin
                    w_reg     <= q_rdata;
                    h_pid_reg <= q_rdata;
                    h_bit_reg <= s_reg;
                    h_set_reg <= 1'b1;
                    h_ret_reg <= B_WDONE;
                    state_reg <= B_HRD;
                end
                B_WDONE:
                begin
                    e_status_reg <= nst_pkg::ST_OK;
                    e_action_reg <= nst_pkg::ACT_WAKE;
                    if (it_reg.op == nst_pkg::OP_POST)
                    begin
                        e_pid_reg  <= w_reg;
                        e_last_reg <= 1'b1;
                        e_ret_reg  <= B_IDLE;
                        state_reg  <= B_EMIT;
                    end
                    else
                    begin
                        e_pid_reg      <= pend_pid_reg;
                        e_last_reg     <= 1'b0;
                        e_ret_reg      <= C_NEXT;
                        state_reg      <= pend_valid_reg ? B_EMIT : C_NEXT;
                        pend_pid_reg   <= w_reg;
                        pend_valid_reg <= 1'b1;
                    end
                end
                B_EMIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_status_reg <= e_status_reg;
                        out_action_reg <= e_action_reg;
                        out_pid_reg    <= e_pid_reg;
                        out_last_reg   <= e_last_reg;
                        state_reg      <= e_ret_reg;
                    end
                end
                C_HMRD:
                begin
                    s_reg          <= '0;
                    pend_valid_reg <= 1'b0;
                    state_reg      <= C_HMWT;
                end
                C_HMWT:
                begin
                    hm_reg    <= hvalid_reg[PW'(it_reg.tpid)] ? h_rdata : '0;
                    state_reg <= C_SLOT;
                end
                C_SLOT:
                begin
                    i_reg      <= '0;
                    n_reg      <= '0;
                    hit_reg    <= 1'b0;
                    rd_idx_reg <= head_reg[s_reg];
                    state_reg  <= (users_reg[s_reg] != '0) ? C_SCAN_RD : C_NEXT;
                end
                C_SCAN_RD:
                begin
                    if (i_reg < fill_reg[s_reg])
                    begin
                        rd_idx_reg <= rd_idx_reg + PW'(1);
                        state_reg  <= C_SCAN_WT;
                    end
                    else
                    begin
                        i_reg     <= '0;
                        state_reg <= hit_reg ? C_COPY_RD : C_HELD;
                    end
                end
                C_SCAN_WT:
                begin
                    if (q_rdata != it_reg.tpid)
                    begin
                        n_reg <= n_reg + FW'(1);
                    end
                    else
                    begin
                        hit_reg <= 1'b1;
                    end
                    i_reg     <= i_reg + FW'(1);
                    state_reg <= C_SCAN_RD;
                end
                C_COPY_RD:
                begin
                    if (i_reg < n_reg)
                    begin
                        state_reg <= C_COPY_WT;
                    end
                    else
                    begin
                        head_reg[s_reg] <= '0;
                        tail_reg[s_reg] <= PW'(n_reg);
                        fill_reg[s_reg] <= n_reg;
                        state_reg       <= C_HELD;
                    end
                end
                C_COPY_WT:
                begin
                    i_reg     <= i_reg + FW'(1);
                    state_reg <= C_COPY_RD;
                end
                C_HELD:
                begin
                    state_reg <= (hm_reg[s_reg] && c_inc <= 0 && fill_reg[s_reg] != '0)
                                 ? B_POP_RD : C_NEXT;
                end
                C_NEXT:
                begin
                    s_reg     <= s_reg + SW'(1);
                    state_reg <= (s_reg == SW'(nst_pkg::SEM_SLOTS - 1)) ? C_END : C_SLOT;
                end
                C_END:
                begin
                    e_status_reg <= nst_pkg::ST_OK;
                    e_action_reg <= pend_valid_reg ? nst_pkg::ACT_WAKE : nst_pkg::ACT_NONE;
                    e_pid_reg    <= pend_valid_reg ? pend_pid_reg : '0;
                    e_last_reg   <= 1'b1;
                    e_ret_reg    <= B_IDLE;
                    state_reg    <= B_EMIT;
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == B_POP_RD |-> fill_reg[s_reg] != '0)
        else $error("pop from empty wait queue");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg[s_reg] <= FW'(nst_pkg::PROCESS_SLOTS))
        else $error("wait queue fill above capacity");

    a_copy_needs_hit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == C_COPY_WT |-> hit_reg && i_reg < n_reg)
        else $error("queue compaction without a removed entry");

    a_kept_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == C_SCAN_WT |=> n_reg <= i_reg)
        else $error("kept count exceeds scanned count");
`endif

endmodule

>>> src/named_semaphore_table_unit.sv
// Named semaphore table, top level: decode stage, command queue, execution engine.
// Depends on nst_pkg, nst_front, nst_fifo and nst_back.
//
// Open, wait and close pass these steps from the engine picking up the command
// to the result transfer: compare the name against all 32 slots, pick the slot,
// then the table update plus a read and write of the held map where needed;
// post adds a pop from the wait queue and a held-map update when it wakes a waiter.
// Cleanup walks every slot: it scans the queued ids of each used slot, repacks
// the queue where the process was queued and wakes a waiter where one is due.
// The decode stage and a two-entry queue take new commands while the engine
// works; a finished result waits in an output register without stopping the
// engine's next command.
module named_semaphore_table_unit (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [111:0] s_tdata,   // name_key, initial_value, caller_pid, caller_valid, target_pid
    input  logic [2:0]   s_tuser,   // command
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [15:0]  m_tdata,   // status, action, action_pid
    output logic         m_tlast
);

    logic           f_valid;
    logic           f_ready;
    nst_pkg::item_t f_item;
    logic           q_valid;
    logic           q_ready;
    nst_pkg::item_t q_item;

    nst_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_tvalid), .in_ready(s_tready), .in_cmd(s_tuser), .in_data(s_tdata),
        .out_valid(f_valid), .out_ready(f_ready), .out_item(f_item)
    );

    nst_fifo u_fifo (
        .clk(clk), .rst_n(rst_n),
        .push_valid(f_valid), .push_ready(f_ready), .push_item(f_item),
        .pop_valid(q_valid), .pop_ready(q_ready), .pop_item(q_item)
    );

    nst_back u_back (
        .clk(clk), .rst_n(rst_n),
        .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd_item(q_item),
        .res_valid(m_tvalid), .res_ready(m_tready), .res_data(m_tdata), .res_last(m_tlast)
    );

endmodule

>>> tb/nst_checker.sv
// Result checker for the named semaphore table: watches both stream channels,
// keeps its own copy of the semaphore table and compares every result transfer.
// Depends on nst_pkg.
`timescale 1ns / 1ps

module nst_checker
    import nst_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [111:0] s_tdata,
    input  logic [2:0]   s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [15:0]  m_tdata,
    input  logic         m_tlast,
    output int           fail_count,
    output int           pending,
    output int           cmd_count,
    output int           result_count,
    output int           wake_count
);

    typedef struct {
        logic [1:0] status;
        logic [1:0] action;
        logic [5:0] pid;
        logic       last;
    } sem_result_t;

    sem_result_t              expected_results[$];
    logic [KEY_W-1:0]         name_tab[SEM_SLOTS];
    logic signed [VAL_W-1:0]  count_tab[SEM_SLOTS];
    logic [USERS_W-1:0]       users_tab[SEM_SLOTS];
    logic [PID_W-1:0]         waiters[SEM_SLOTS][$];
    logic [SEM_SLOTS-1:0]     held[PROCESS_SLOTS];

    task automatic report(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        fail_count++;
    endtask

    task automatic push_result(input logic [1:0] st, input logic [1:0] act,
                               input logic [5:0] pid, input logic last);
        sem_result_t r;
        r.status = st;
        r.action = act;
        r.pid    = pid;
        r.last   = last;
        expected_results.push_back(r);
    endtask

    function automatic int lookup(input logic [KEY_W-1:0] key);
        for (int i = 0; i < SEM_SLOTS; i++)
            if (users_tab[i] != 0 && ((name_tab[i] ^ key) & KEY_MASK) == 0)
                return i;
        return -1;
    endfunction

    function automatic logic signed [VAL_W-1:0] bump_up(input logic signed [VAL_W-1:0] v);
        if (v == VAL_MAX)
            return v;
        return v + 1;
    endfunction

    task automatic apply_command(input logic [2:0] cmd, input logic [111:0] d);
        logic [KEY_W-1:0]  key;
        logic [INIT_W-1:0] init;
        logic [PID_W-1:0]  cpid;
        logic              cvalid;
        logic [PID_W-1:0]  tpid;
        logic [PID_W-1:0]  w;
        logic [PID_W-1:0]  kept[$];
        sem_result_t       wakes[$];
        sem_result_t       r;
        bit                hit;
        int                s;
        int                free_slot;
        key    = d[63:0] & KEY_MASK;
        init   = d[94:64];
        cpid   = d[100:95];
        cvalid = d[101];
        tpid   = d[107:102];
        case (cmd)
            CMD_OPEN:
            begin
                s = lookup(key);
                if (s >= 0)
                begin
                    if (users_tab[s] != 8'hFF)
                        users_tab[s]++;
                    push_result(ST_OK, ACT_NONE, 0, 1);
                end
                else
                begin
                    free_slot = -1;
                    for (int i = SEM_SLOTS - 1; i >= 0; i--)
                        if (users_tab[i] == 0)
                            free_slot = i;
                    if (free_slot < 0)
                        push_result(ST_FULL, ACT_NONE, 0, 1);
                    else
                    begin
                        name_tab[free_slot]  = key;
                        count_tab[free_slot] = {1'b0, init};
                        users_tab[free_slot] = 1;
                        waiters[free_slot].delete();
                        push_result(ST_OK, ACT_NONE, 0, 1);
                    end
                end
            end
            CMD_WAIT, CMD_POST, CMD_CLOSE:
            begin
                s = lookup(key);
                if (s < 0)
                    push_result(ST_NOTFOUND, ACT_NONE, 0, 1);
                else if (cmd == CMD_WAIT)
                begin
                    if (count_tab[s] != VAL_MIN)
                        count_tab[s] = count_tab[s] - 1;
                    if (count_tab[s] < 0)
                    begin
                        if (!cvalid)
                            push_result(ST_NOTFOUND, ACT_NONE, 0, 1);
                        else
                        begin
                            if (waiters[s].size() < PROCESS_SLOTS)
                                waiters[s].push_back(cpid);
                            push_result(ST_OK, ACT_BLOCK, cpid, 1);
                        end
                    end
                    else
                    begin
                        if (cvalid)
                            held[cpid][s] = 1'b1;
                        push_result(ST_OK, ACT_NONE, 0, 1);
                    end
                end
                else if (cmd == CMD_POST)
                begin
                    if (cvalid)
                        held[cpid][s] = 1'b0;
                    count_tab[s] = bump_up(count_tab[s]);
                    if (count_tab[s] <= 0 && waiters[s].size() > 0)
                    begin
                        w = waiters[s].pop_front();
                        held[w][s] = 1'b1;
                        push_result(ST_OK, ACT_WAKE, w, 1);
                    end
                    else
                        push_result(ST_OK, ACT_NONE, 0, 1);
                end
                else
                begin
                    if (cvalid)
                        held[cpid][s] = 1'b0;
                    users_tab[s]--;
                    if (users_tab[s] == 0)
                    begin
                        name_tab[s] = 0;
                        waiters[s].delete();
                    end
                    push_result(ST_OK, ACT_NONE, 0, 1);
                end
            end
            CMD_CLEANUP:
            begin
                for (int i = 0; i < SEM_SLOTS; i++)
                begin
                    if (users_tab[i] != 0)
                    begin
                        kept.delete();
                        hit = 0;
                        foreach (waiters[i][j])
                            if (waiters[i][j] != tpid)
                                kept.push_back(waiters[i][j]);
                            else
                                hit = 1;
                        if (hit)
                        begin
                            waiters[i] = kept;
                            count_tab[i] = bump_up(count_tab[i]);
                        end
                        if (held[tpid][i])
                        begin
                            held[tpid][i] = 1'b0;
                            count_tab[i] = bump_up(count_tab[i]);
                            if (count_tab[i] <= 0 && waiters[i].size() > 0)
                            begin
                                w = waiters[i].pop_front();
                                held[w][i] = 1'b1;
                                r.status = ST_OK;
                                r.action = ACT_WAKE;
                                r.pid    = w;
                                r.last   = 0;
                                wakes.push_back(r);
                            end
                        end
                    end
                end
                held[tpid] = '0;
                if (wakes.size() == 0)
                    push_result(ST_OK, ACT_NONE, 0, 1);
                else
                begin
                    wakes[wakes.size() - 1].last = 1;
                    foreach (wakes[j])
                        expected_results.push_back(wakes[j]);
                end
            end
            default:
                push_result(ST_NOTFOUND, ACT_NONE, 0, 1);
        endcase
    endtask

    initial
    begin
        fail_count   = 0;
        cmd_count    = 0;
        result_count = 0;
        wake_count   = 0;
        for (int i = 0; i < SEM_SLOTS; i++)
        begin
            name_tab[i]  = '0;
            count_tab[i] = '0;
            users_tab[i] = '0;
        end
        for (int i = 0; i < PROCESS_SLOTS; i++)
            held[i] = '0;
    end

    assign pending = expected_results.size();

    always @(posedge clk)
    begin
        sem_result_t e;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                apply_command(s_tuser, s_tdata);
                cmd_count++;
            end
            if (m_tvalid && m_tready)
            begin
                result_count++;
                if (m_tdata[3:2] == ACT_WAKE)
                    wake_count++;
                if (expected_results.size() == 0)
                    report($sformatf("unexpected result tdata=%h tlast=%b", m_tdata, m_tlast));
                else
                begin
                    e = expected_results.pop_front();
                    if (m_tdata[1:0] !== e.status)
                        report($sformatf("status %0d, want %0d", m_tdata[1:0], e.status));
                    if (m_tdata[3:2] !== e.action)
                        report($sformatf("action %0d, want %0d", m_tdata[3:2], e.action));
                    if (m_tdata[9:4] !== e.pid)
                        report($sformatf("action_pid %0d, want %0d", m_tdata[9:4], e.pid));
                    if (m_tlast !== e.last)
                        report($sformatf("tlast %b, want %b", m_tlast, e.last));
                end
            end
        end
    end

endmodule

>>> tb/tb.sv
// Testbench top for named_semaphore_table_unit: clock, reset, command stimulus
// with sender gaps and receiver stalls, watchdog and verdict. Uses nst_checker.
`timescale 1ns / 1ps

module tb;
    import nst_pkg::*;

    localparam int IDLE_LIMIT = 40000;
    localparam int HOLD_CYCLES = 400;

    logic         clk = 0;
    logic         rst_n = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [111:0] s_tdata = '0;
    logic [2:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [15:0]  m_tdata;
    logic         m_tlast;

    int fail_count, pending, cmd_count, result_count, wake_count;
    int send_gap_pct = 0;
    int stall_pct = 0;
    int hold_left = 0;
    int idle_cycles = 0;
    bit hold_req = 0;
    bit hold_seen = 0;
    logic [KEY_W-1:0] names[6];

    always #6 clk = ~clk;

    named_semaphore_table_unit uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    nst_checker chk (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .fail_count(fail_count), .pending(pending), .cmd_count(cmd_count),
        .result_count(result_count), .wake_count(wake_count)
    );

    // hold off the receiver for a long stretch on request
    always @(posedge clk)
    begin
        if (hold_req != hold_seen)
        begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Timeout: no transfer for %0d cycles", IDLE_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic send(input logic [2:0] cmd, input logic [63:0] key,
                        input logic [30:0] init, input logic [5:0] cpid,
                        input logic cvalid, input logic [5:0] tpid);
        if ($urandom_range(0, 99) < send_gap_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {4'b0, tpid, cvalid, cpid, init, key};
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        wait (pending == 0);
        repeat (60) @(posedge clk);
    endtask

    task automatic random_command();
        logic [2:0]  cmd;
        logic [63:0] key;
        logic [30:0] init;
        logic [5:0]  cpid;
        logic [5:0]  tpid;
        int          pick;
        pick = $urandom_range(0, 99);
        if (pick < 15)      cmd = CMD_OPEN;
        else if (pick < 45) cmd = CMD_WAIT;
        else if (pick < 72) cmd = CMD_POST;
        else if (pick < 82) cmd = CMD_CLOSE;
        else if (pick < 96) cmd = CMD_CLEANUP;
        else                cmd = 3'(OP_BAD) + 3'($urandom_range(0, 2));
        key  = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom} : names[$urandom_range(0, 5)];
        init = ($urandom_range(0, 7) == 0) ? 31'($urandom) : 31'($urandom_range(0, 2));
        cpid = ($urandom_range(0, 7) == 0) ? 6'($urandom) : 6'($urandom_range(0, 7));
        tpid = ($urandom_range(0, 7) == 0) ? 6'($urandom) : 6'($urandom_range(0, 7));
        send(cmd, key, init, cpid, $urandom_range(0, 15) != 0, tpid);
    endtask

    initial
    begin
        names[0] = 64'h0;
        names[1] = 64'hFFFF_FFFF_FFFF_FFFF;
        names[2] = 64'h0000_0000_6D75_7465;
        names[3] = 64'h6B63_6F6C_5F62_7573;
        names[4] = 64'h0000_0000_0000_0061;
        names[5] = 64'h8000_0000_0000_0001;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(CMD_POST, names[0], 0, 1, 1, 0);
        send(CMD_OPEN, names[0], 0, 1, 1, 0);
        send(CMD_OPEN, names[0], 5, 2, 1, 0);
        send(CMD_WAIT, names[0], 0, 1, 1, 0);
        send(CMD_WAIT, names[0], 0, 2, 1, 0);
        send(CMD_WAIT, names[0], 0, 3, 0, 0);
        send(CMD_WAIT, names[0], 0, 63, 1, 0);
        send(CMD_POST, names[0], 0, 5, 1, 0);
        send(CMD_OPEN, names[1], 31'h7FFF_FFFF, 4, 1, 0);
        send(CMD_POST, names[1], 0, 4, 1, 0);
        send(CMD_WAIT, names[1], 0, 4, 1, 0);
        send(CMD_WAIT, names[0], 0, 4, 1, 0);
        send(CMD_CLEANUP, 0, 0, 0, 0, 4);
        send(CMD_CLEANUP, 0, 0, 0, 0, 63);
        send(CMD_CLEANUP, 0, 0, 0, 0, 4);
        send(3'(OP_BAD), names[0], 0, 1, 1, 0);
        send(3'd7, names[1], 0, 1, 1, 0);
        send(CMD_CLOSE, names[0], 0, 1, 1, 0);
        send(CMD_CLOSE, names[0], 0, 1, 0, 0);
        send(CMD_CLOSE, names[0], 0, 1, 1, 0);
        send(CMD_CLOSE, names[1], 0, 4, 1, 0);
        drain();

        // fill the table, overflow it, then free every slot
        for (int i = 0; i <= SEM_SLOTS; i++)
            send(CMD_OPEN, 64'h1000 + i, 31'(i), 6'(i), 1, 0);
        for (int i = 0; i < SEM_SLOTS; i++)
            send(CMD_CLOSE, 64'h1000 + i, 0, 6'(i), 1, 0);
        drain();

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin send_gap_pct = 0;  stall_pct = 0;  end
                1: begin send_gap_pct = 61; stall_pct = 0;  end
                2: begin send_gap_pct = 0;  stall_pct = 61; end
                default: begin send_gap_pct = 24; stall_pct = 24; end
            endcase
            for (int n = 0; n < 45; n++)
            begin
                if (phase == 0 && n == 10)
                    hold_req <= ~hold_req;
                random_command();
            end
            drain();
        end

        $display("Covered %0d commands and %0d results (%0d wakes) across gap and stall mixes,",
                 cmd_count, result_count, wake_count);
        $display("including a full table, saturation, cleanup wakes and a long receiver hold-off.");
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
